>>> sv/spectrum_peak_decimator_assert.svh
// Assertion macros shared by the peak decimator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SPECTRUM_PEAK_DECIMATOR_ASSERT_SVH
`define SPECTRUM_PEAK_DECIMATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPD_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/spd_pkg.sv
// Package for the spectrum peak decimator: field widths, codes, status structs
// and the level mapping function. Depends on nothing.
package spd_pkg;

  localparam int IDX_W     = 12;
  localparam int BIN_W     = 16;
  localparam int CNT_W     = 13;
  localparam int CAL_W     = 16;
  localparam int LVL_W     = 8;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;
  localparam int SUM_W     = 18;

  localparam int BINS_DEFAULT = 4096;

  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd1024;
  localparam logic [CAL_W-1:0] CAL_RESET   = 16'd0;
  localparam logic [LVL_W-1:0] LEVEL_MAX   = 8'd255;

  // Operation codes of an input item.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register index, taken from paddr bit 2.
  localparam logic REG_OUTPUT_COUNT = 1'b0;
  localparam logic REG_CAL_OFFSET   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } spd_div_sts_t;

  typedef struct packed {
    logic                    done;
    logic                    any;
    logic signed [BIN_W-1:0] peak;
  } spd_scan_sts_t;

  // Peak plus calibration, negated, truncated to whole dB and saturated.
  function automatic logic [LVL_W-1:0] level_of(logic signed [BIN_W-1:0] peak,
                                                logic any,
                                                logic signed [CAL_W-1:0] cal);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] q;
    logic [LVL_W-1:0]        lvl;
    s = SUM_W'(peak) + SUM_W'(cal);
    q = -s;
    if (!any) begin
      lvl = LEVEL_MAX;
    end else if (q <= 18'sd0) begin
      lvl = '0;
    end else if (q[SUM_W-1:4] > 14'd255) begin
      lvl = LEVEL_MAX;
    end else begin
      lvl = q[LVL_W+3:4];
    end
    return lvl;
  endfunction

endpackage

>>> sv/spd_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on spd_pkg for the field widths.
interface spd_in_if import spd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [IDX_W-1:0]        bin_index;
  logic signed [BIN_W-1:0] bin_value;
  logic [IDX_W-1:0]        point_index;

  modport source (output valid, operation, bin_index, bin_value, point_index,
                  input ready);
  modport sink (input valid, operation, bin_index, bin_value, point_index,
                output ready);
endinterface

interface spd_out_if import spd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] point_number;
  logic [LVL_W-1:0] display_level;

  modport source (output valid, point_number, display_level, input ready);
  modport sink (input valid, point_number, display_level, output ready);
endinterface

>>> sv/spd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module spd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/spd_div.sv
// Restoring divider, one quotient bit per cycle, for the window bounds.
// Depends on spd_pkg and the assertion macro header.
`include "spectrum_peak_decimator_assert.svh"

module spd_div import spd_pkg::*; #(
  parameter int NW = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NW-1:0]    num,
  input  logic [CNT_W-1:0] den,
  output logic [NW-1:0]    quo,
  output spd_div_sts_t     sts
);

  localparam int CW = $clog2(NW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] den_r, den_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  // The numerator shifts out of the top of quo_r while quotient bits enter below.
  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quo      = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  `SPD_ASSERT_IMPL(a_div_start_idle, clk, rst_n, start, !busy_r,
                   "divider started while busy")

endmodule

>>> sv/spd_scan.sv
// Window scan: reads the bin store from lo up to hi - 1 and keeps the peak.
// Depends on spd_pkg and the assertion macro header.
`include "spectrum_peak_decimator_assert.svh"

module spd_scan import spd_pkg::*; #(
  parameter int AW = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [AW:0]             lo,
  input  logic [AW:0]             hi,
  output logic                    rd_en,
  output logic [AW-1:0]           rd_addr,
  input  logic signed [BIN_W-1:0] rd_data,
  output spd_scan_sts_t           sts
);

  localparam int CW = AW + 1;

  logic                    active_r, active_nxt;
  logic [AW:0]             cur_r, cur_nxt;
  logic [AW:0]             hi_r, hi_nxt;
  logic                    rv_r, rv_nxt;
  logic                    last_r, last_nxt;
  logic                    any_r, any_nxt;
  logic                    done_r, done_nxt;
  logic signed [BIN_W-1:0] peak_r, peak_nxt;

  always_comb begin
    active_nxt = active_r;
    cur_nxt    = cur_r;
    hi_nxt     = hi_r;
    rv_nxt     = 1'b0;
    last_nxt   = 1'b0;
    any_nxt    = any_r;
    done_nxt   = 1'b0;
    peak_nxt   = peak_r;
    if (start) begin
      cur_nxt    = lo;
      hi_nxt     = hi;
      any_nxt    = 1'b0;
      active_nxt = lo < hi;
      // An empty window finishes at once and reads as the display floor.
      done_nxt   = !(lo < hi);
    end else begin
      if (active_r) begin
        rv_nxt   = 1'b1;
        cur_nxt  = cur_r + CW'(1);
        last_nxt = (cur_r + CW'(1)) == hi_r;
        if ((cur_r + CW'(1)) == hi_r) begin
          active_nxt = 1'b0;
        end
      end
      // Read data lands in the cycle after its address was issued.
      if (rv_r) begin
        if (!any_r || rd_data > peak_r) begin
          peak_nxt = rd_data;
          any_nxt  = 1'b1;
        end
        done_nxt = last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      rv_r     <= 1'b0;
      last_r   <= 1'b0;
      any_r    <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      rv_r     <= rv_nxt;
      last_r   <= last_nxt;
      any_r    <= any_nxt;
      done_r   <= done_nxt;
    end
    cur_r  <= cur_nxt;
    hi_r   <= hi_nxt;
    peak_r <= peak_nxt;
  end

  assign rd_en    = active_r;
  assign rd_addr  = cur_r[AW-1:0];
  assign sts.done = done_r;
  assign sts.any  = any_r;
  assign sts.peak = peak_r;

  `SPD_ASSERT_IMPL(a_scan_start_idle, clk, rst_n, start, !active_r && !rv_r,
                   "scan started while a window is in progress")
  `SPD_ASSERT_NEXT(a_scan_last_done, clk, rst_n, rv_r && last_r, done_r && any_r,
                   "last read of a window did not finish the scan")

endmodule

>>> sv/spectrum_peak_decimator.sv
// Top level of the spectrum peak decimator: APB registers, control sequencer,
// bin store, bound divider and window scan. Depends on spd_pkg, spd_if,
// spd_ram, spd_div, spd_scan and the assertion macro header.
//
//   Port group   Direction  Carries
//   in_chan      sink       bin writes and display point requests
//   out_chan     source     point number and display level per request
//   APB (p*)     slave      output_count at 0x0, calibration_offset at 0x4
//
// A bin write goes straight into the store. A point request runs two bound
// divisions, then reads one bin per cycle across the window (W bins, about
// BINS/count) and keeps the peak; one item is taken at a time, and the next
// only once the result has been loaded for out_chan. Reset is synchronous,
// active low and leaves the bin store undefined. A result still waiting on
// out_chan stalls the sequencer in S_OUT while out_chan.ready is low.
`include "spectrum_peak_decimator_assert.svh"

module spectrum_peak_decimator import spd_pkg::*; #(
  parameter int BINS = BINS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  spd_in_if.sink             in_chan,
  spd_out_if.source          out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int AW = $clog2(BINS);
  localparam int PW = AW + 1;
  localparam int NW = IDX_W + 1 + AW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LO   = 5'b00010,
    S_HI   = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic signed [CAL_W-1:0] cal_r;
  logic [IDX_W-1:0]        pt_r, pt_nxt;
  logic [PW-1:0]           lo_r, lo_nxt;
  logic [LVL_W-1:0]        level_r, level_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_pt_r;
  logic [LVL_W-1:0]        out_lvl_r;

  logic                    in_acc;
  logic                    cfg_wr;
  logic                    ram_we;
  logic [BIN_W-1:0]        ram_rdata;
  logic                    div_start;
  logic [NW-1:0]           div_num;
  logic [CNT_W-1:0]        div_den;
  logic [NW-1:0]           div_quo;
  spd_div_sts_t            div_sts;
  logic [PW-1:0]           quo_cl;
  logic                    scan_start;
  logic                    scan_rd_en;
  logic [AW-1:0]           scan_rd_addr;
  spd_scan_sts_t           scan_sts;
  logic                    out_load;

  // Configuration registers.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      cal_r   <= CAL_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CAL_OFFSET) begin
        cal_r <= pwdata[CAL_W-1:0];
      end else begin
        count_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_CAL_OFFSET) ?
                  {{(DATA_W-CAL_W){cal_r[CAL_W-1]}}, cal_r} :
                  {{(DATA_W-CNT_W){1'b0}}, count_r};

  // Input side: one item at a time, bin writes go straight into the store.
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign ram_we        = in_acc && (in_chan.operation == OP_WRITE) &&
                         (32'(in_chan.bin_index) < 32'(BINS));

  spd_ram #(
    .WIDTH (BIN_W),
    .DEPTH (BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_chan.bin_index)),
    .wdata (in_chan.bin_value),
    .re    (scan_rd_en),
    .raddr (scan_rd_addr),
    .rdata (ram_rdata)
  );

  // Window bounds: lo = pt*BINS/count first, then hi = (pt+1)*BINS/count, both clamped to BINS.
  assign div_start = (in_acc && (in_chan.operation == OP_READ)) ||
                     ((state_r == S_LO) && div_sts.done);
  assign div_num   = (state_r == S_IDLE) ?
                     NW'(in_chan.point_index) * NW'(BINS) :
                     (NW'(pt_r) + NW'(1)) * NW'(BINS);
  assign div_den   = (count_r == '0) ? CNT_W'(1) : count_r;
  assign quo_cl    = (div_quo > NW'(BINS)) ? PW'(BINS) : PW'(div_quo);

  spd_div #(
    .NW (NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  assign scan_start = (state_r == S_HI) && div_sts.done;

  spd_scan #(
    .AW (AW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .lo      (lo_r),
    .hi      (quo_cl),
    .rd_en   (scan_rd_en),
    .rd_addr (scan_rd_addr),
    .rd_data (signed'(ram_rdata)),
    .sts     (scan_sts)
  );

  // Sequencer.
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    pt_nxt    = pt_r;
    lo_nxt    = lo_r;
    level_nxt = level_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_chan.operation == OP_READ)) begin
          pt_nxt    = in_chan.point_index;
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        if (div_sts.done) begin
          lo_nxt    = quo_cl;
          state_nxt = S_HI;
        end
      end
      S_HI: begin
        if (div_sts.done) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_sts.done) begin
          level_nxt = level_of(scan_sts.peak, scan_sts.any, cal_r);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pt_r    <= pt_nxt;
    lo_r    <= lo_nxt;
    level_r <= level_nxt;
    if (out_load) begin
      out_pt_r  <= pt_r;
      out_lvl_r <= level_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.point_number  = out_pt_r;
  assign out_chan.display_level = out_lvl_r;

  `SPD_ASSERT_IMPL(a_div_done_state, clk, rst_n, div_sts.done,
                   (state_r == S_LO) || (state_r == S_HI),
                   "divider finished outside a bound phase")
  `SPD_ASSERT_IMPL(a_scan_done_state, clk, rst_n, scan_sts.done, state_r == S_SCAN,
                   "window scan finished outside the scan phase")
  `SPD_ASSERT_IMPL(a_write_quiet, clk, rst_n, ram_we, !scan_rd_en && !div_sts.busy,
                   "bin write overlaps a point request in progress")

endmodule
